### design/sfs_pkg.sv
// Package for the sprite frame sequencer: configuration, command and status types,
// register map and input kind codes. No dependencies.
`default_nettype none

package sfs_pkg;

  localparam int MAX_FRAMES_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DELTA_FRAC     = 16;
  localparam int CFG_AW         = 5;
  localparam int CFG_DW         = 32;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_RESTART = 2'd1;
  localparam logic [1:0] KIND_TABLE   = 2'd2;

  localparam logic [2:0] REG_FRAME_COUNT   = 3'd0;
  localparam logic [2:0] REG_FRAME_RATE    = 3'd1;
  localparam logic [2:0] REG_SHEET_COLUMNS = 3'd2;
  localparam logic [2:0] REG_MODE_FLAGS    = 3'd3;
  localparam logic [2:0] REG_UV_ORIGIN_X   = 3'd4;
  localparam logic [2:0] REG_UV_ORIGIN_Y   = 3'd5;
  localparam logic [2:0] REG_UV_STEP_X     = 3'd6;
  localparam logic [2:0] REG_UV_STEP_Y     = 3'd7;

  localparam int MODE_LOOP     = 0;
  localparam int MODE_PINGPONG = 1;
  localparam int MODE_TABLE    = 2;

  typedef struct packed {
    logic [6:0]  frame_count;
    logic [7:0]  frame_rate;
    logic [6:0]  sheet_columns;
    logic [2:0]  mode_flags;
    logic [15:0] uv_origin_x;
    logic [15:0] uv_origin_y;
    logic [15:0] uv_step_x;
    logic [15:0] uv_step_y;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic restart;
    logic table_write;
    logic add;
    logic wrap;
    logic fold;
    logic read;
    logic split;
    logic scale;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

`default_nettype wire

### design/sfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sfs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/sfs_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, 7-bit divisor.
// No dependencies.
`default_nettype none

module sfs_divider #(
  parameter int DW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [6:0]    divisor_i,
  output logic      [DW-1:0] quotient_o,
  output logic      [6:0]    remainder_o,
  output logic               done_o
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW-1:0] quo_q, quo_d;
  logic [6:0]    rem_q, rem_d;
  logic [6:0]    dvs_q;
  logic [7:0]    trial;
  logic [7:0]    diff;
  logic          ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};
  assign rem_d = ge ? diff[6:0] : trial[6:0];
  assign quo_d = {quo_q[DW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

`default_nettype wire

### design/sfs_ctrl.sv
// Sequencer for the sprite frame sequencer: input and output handshakes and datapath commands.
// Depends on sfs_pkg.
`default_nettype none

module sfs_ctrl
  import sfs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] kind_i,
  output logic            in_ready_o,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output dp_cmd_t         cmd_o,
  input  dp_stat_t        stat_i
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_ADD   = 10'b00_0000_0010,
    S_WRAP  = 10'b00_0000_0100,
    S_MOD   = 10'b00_0000_1000,
    S_FOLD  = 10'b00_0001_0000,
    S_READ  = 10'b00_0010_0000,
    S_SPLIT = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_SCALE = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  dp_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (kind_i)
            KIND_TICK, KIND_RESTART: begin
              cmd.take    = 1'b1;
              cmd.restart = (kind_i == KIND_RESTART);
              state_d     = S_ADD;
            end
            KIND_TABLE: begin
              cmd.table_write = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_ADD: begin
        cmd.add = 1'b1;
        state_d = S_WRAP;
      end
      S_WRAP: begin
        cmd.wrap = 1'b1;
        state_d  = S_MOD;
      end
      S_MOD: begin
        if (stat_i.div_done) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        state_d  = S_READ;
      end
      S_READ: begin
        cmd.read = 1'b1;
        state_d  = S_SPLIT;
      end
      S_SPLIT: begin
        cmd.split = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

### design/sfs_datapath.sv
// Datapath of the sprite frame sequencer: position, wrap, frame fold, frame table,
// column/row split and texture offsets. Depends on sfs_pkg, sfs_ram, sfs_divider.
`default_nettype none

module sfs_datapath
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  cfg_t             cfg_i,
  input  dp_cmd_t          cmd_i,
  output dp_stat_t         stat_o,
  input  wire logic [15:0] elapsed_i,
  input  wire logic [5:0]  table_index_i,
  input  wire logic [11:0] table_value_i,
  output logic      [11:0] sheet_frame_o,
  output logic      [31:0] uv_u_o,
  output logic      [31:0] uv_v_o,
  output logic             reversed_o,
  output logic             finished_o
);

  localparam int FW = 32 - FRAC_BITS;
  localparam int DW = (FW > 12) ? FW : 12;
  localparam int AW = $clog2(MAX_FRAMES);

  logic [23:0]   prod_q;
  logic [31:0]   pos_q;
  logic          dir_q;
  logic [31:0]   sum_q;
  logic [6:0]    frame_q;
  logic          fin_q;
  logic          in_table_q;
  logic [11:0]   sprite_q;
  logic [22:0]   mu_q;
  logic [27:0]   mv_q;
  logic [11:0]   sheet_frame_q;
  logic [31:0]   uv_u_q, uv_v_q;
  logic          rev_q, fin_out_q;

  logic [6:0]    cnt_eff, cm1, cols_eff;
  logic [47:0]   inc_w;
  logic [32:0]   sum_w;
  logic [31:0]   sat_w;
  logic [32:0]   end_w, sub_w;
  logic          wrap_w;
  logic [31:0]   pos_d;
  logic [FW-1:0] frame_full;
  logic [6:0]    frame_sel, frame_d;
  logic [11:0]   sprite_w;
  logic [32:0]   uu_w, vv_w;
  logic [15:0]   frame_wide, idx_wide;
  logic          ram_we;
  logic [11:0]   ram_rdata;
  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [6:0]    div_divisor;
  logic [DW-1:0] div_quo;
  logic [6:0]    div_rem;
  logic          div_done;

  assign cnt_eff  = (cfg_i.frame_count == 7'd0) ? 7'd1 : cfg_i.frame_count;
  assign cols_eff = (cfg_i.sheet_columns == 7'd0) ? 7'd1 : cfg_i.sheet_columns;
  assign cm1      = cnt_eff - 7'd1;

  assign inc_w = ({24'd0, prod_q} << FRAC_BITS) >> DELTA_FRAC;
  assign sum_w = {1'b0, pos_q} + {1'b0, inc_w[31:0]};
  assign sat_w = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];

  assign end_w  = {26'd0, cnt_eff} << FRAC_BITS;
  assign sub_w  = cfg_i.mode_flags[MODE_PINGPONG] ? ({26'd0, cm1} << FRAC_BITS) : end_w;
  assign wrap_w = {1'b0, sum_q} > end_w;
  assign pos_d  = wrap_w ? (sum_q - sub_w[31:0]) : sum_q;

  assign frame_full = sum_q[31:FRAC_BITS];

  always_comb begin
    if (cfg_i.mode_flags[MODE_LOOP]) begin
      frame_sel = div_rem;
    end else if (32'(frame_full) > 32'(cm1)) begin
      frame_sel = cm1;
    end else begin
      frame_sel = frame_full[6:0];
    end
    frame_d = dir_q ? (cm1 - frame_sel) : frame_sel;
  end

  assign frame_wide = {9'd0, frame_q};
  assign idx_wide   = {10'd0, table_index_i};
  assign ram_we     = cmd_i.table_write && (32'(table_index_i) < 32'(MAX_FRAMES));

  sfs_ram #(
    .WIDTH(12),
    .DEPTH(MAX_FRAMES)
  ) u_frame_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_wide[AW-1:0]),
    .wdata_i(table_value_i),
    .re_i   (cmd_i.read),
    .raddr_i(frame_wide[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    if (cfg_i.mode_flags[MODE_TABLE]) begin
      sprite_w = in_table_q ? ram_rdata : 12'd0;
    end else begin
      sprite_w = {5'd0, frame_q};
    end
  end

  assign div_start    = cmd_i.wrap | cmd_i.split;
  assign div_dividend = cmd_i.wrap ? DW'(frame_full) : DW'(sprite_w);
  assign div_divisor  = cmd_i.wrap ? cnt_eff : cols_eff;

  sfs_divider #(
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .remainder_o(div_rem),
    .done_o     (div_done)
  );

  assign uu_w = 33'(cfg_i.uv_origin_x) + 33'(mu_q);
  assign vv_w = 33'(cfg_i.uv_origin_y) + 33'(mv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      dir_q <= 1'b0;
    end else if (cmd_i.take && cmd_i.restart) begin
      pos_q <= '0;
      dir_q <= 1'b0;
    end else if (cmd_i.wrap) begin
      pos_q <= pos_d;
      if (wrap_w && cfg_i.mode_flags[MODE_PINGPONG]) begin
        dir_q <= ~dir_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      prod_q <= cmd_i.restart ? 24'd0 : (24'(elapsed_i) * 24'(cfg_i.frame_rate));
    end
    if (cmd_i.add) begin
      sum_q <= sat_w;
    end
    if (cmd_i.fold) begin
      frame_q <= frame_d;
      fin_q   <= !cfg_i.mode_flags[MODE_LOOP] && ({1'b0, pos_q} >= end_w);
    end
    if (cmd_i.read) begin
      in_table_q <= 32'(frame_q) < 32'(MAX_FRAMES);
    end
    if (cmd_i.split) begin
      sprite_q <= sprite_w;
    end
    if (cmd_i.scale) begin
      mu_q <= 23'(cfg_i.uv_step_x) * 23'(div_rem);
      mv_q <= 28'(cfg_i.uv_step_y) * 28'(div_quo[11:0]);
    end
    if (cmd_i.out_load) begin
      sheet_frame_q <= sprite_q;
      uv_u_q        <= uu_w[32] ? 32'hFFFF_FFFF : uu_w[31:0];
      uv_v_q        <= vv_w[32] ? 32'hFFFF_FFFF : vv_w[31:0];
      rev_q         <= dir_q;
      fin_out_q     <= fin_q;
    end
  end

  assign stat_o.div_done = div_done;
  assign sheet_frame_o   = sheet_frame_q;
  assign uv_u_o          = uv_u_q;
  assign uv_v_o          = uv_v_q;
  assign reversed_o      = rev_q;
  assign finished_o      = fin_out_q;

endmodule

`default_nettype wire

### design/sprite_frame_sequencer_top.sv
// Top level of the sprite frame sequencer: APB register file, sequencer and datapath.
// Depends on sfs_pkg, sfs_ctrl, sfs_datapath.
`default_nettype none

// Sprite sheet animation stepper. A tick (kind 0) advances the Q.FRAC_BITS frame
// position by elapsed * frame_rate and returns the shown sheet frame with its
// texture offsets; a restart (kind 1) rewinds to frame zero and returns that result;
// a frame table write (kind 2) returns nothing. One item is in work at a time. The
// shared radix-2 divider, with DW = max(32 - FRAC_BITS, 12), runs once for the frame
// modulo and once for the column/row split. The result sits in an output register,
// so the next item is taken while it waits. Frame table entries read before being
// written return unspecified data.
module sprite_frame_sequencer_top
  import sfs_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        kind_i,
  input  wire logic [15:0]       elapsed_i,
  input  wire logic [5:0]        table_index_i,
  input  wire logic [11:0]       table_value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [11:0]       sheet_frame_o,
  output logic      [31:0]       uv_u_o,
  output logic      [31:0]       uv_v_o,
  output logic                   reversed_o,
  output logic                   finished_o
);

  cfg_t     cfg_q, cfg_d;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     cfg_wr;
  logic [2:0] reg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_COUNT:   cfg_d.frame_count   = pwdata[6:0];
        REG_FRAME_RATE:    cfg_d.frame_rate    = pwdata[7:0];
        REG_SHEET_COLUMNS: cfg_d.sheet_columns = pwdata[6:0];
        REG_MODE_FLAGS:    cfg_d.mode_flags    = pwdata[2:0];
        REG_UV_ORIGIN_X:   cfg_d.uv_origin_x   = pwdata[15:0];
        REG_UV_ORIGIN_Y:   cfg_d.uv_origin_y   = pwdata[15:0];
        REG_UV_STEP_X:     cfg_d.uv_step_x     = pwdata[15:0];
        REG_UV_STEP_Y:     cfg_d.uv_step_y     = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_COUNT:   prdata = {25'd0, cfg_q.frame_count};
      REG_FRAME_RATE:    prdata = {24'd0, cfg_q.frame_rate};
      REG_SHEET_COLUMNS: prdata = {25'd0, cfg_q.sheet_columns};
      REG_MODE_FLAGS:    prdata = {29'd0, cfg_q.mode_flags};
      REG_UV_ORIGIN_X:   prdata = {16'd0, cfg_q.uv_origin_x};
      REG_UV_ORIGIN_Y:   prdata = {16'd0, cfg_q.uv_origin_y};
      REG_UV_STEP_X:     prdata = {16'd0, cfg_q.uv_step_x};
      REG_UV_STEP_Y:     prdata = {16'd0, cfg_q.uv_step_y};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_count   <= 7'd1;
      cfg_q.frame_rate    <= 8'd30;
      cfg_q.sheet_columns <= 7'd1;
      cfg_q.mode_flags    <= 3'd1;
      cfg_q.uv_origin_x   <= '0;
      cfg_q.uv_origin_y   <= '0;
      cfg_q.uv_step_x     <= '0;
      cfg_q.uv_step_y     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_ready_o (in_ready_o),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  sfs_datapath #(
    .MAX_FRAMES(MAX_FRAMES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .elapsed_i    (elapsed_i),
    .table_index_i(table_index_i),
    .table_value_i(table_value_i),
    .sheet_frame_o(sheet_frame_o),
    .uv_u_o       (uv_u_o),
    .uv_v_o       (uv_v_o),
    .reversed_o   (reversed_o),
    .finished_o   (finished_o)
  );

`ifndef SYNTHESIS
  a_frame_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cfg_q.mode_flags[MODE_TABLE] |->
      (sheet_frame_o < {5'd0, cfg_q.frame_count}) || (sheet_frame_o == 12'd0))
    else $error("sheet frame beyond frame count");

  a_uv_above_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (uv_u_o >= {16'd0, cfg_q.uv_origin_x}) &&
                    (uv_v_o >= {16'd0, cfg_q.uv_origin_y}))
    else $error("texture offset below origin");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised without work in progress");
`endif

endmodule

`default_nettype wire
